FILE: hw/rtl/bpc_pkg.sv
// Package for the button press classifier: transfer payload types, event codes
// and control register indexes. No dependencies.
`default_nettype none

package bpc_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned MsWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ACTIVE_HIGH   = 2'd0,
      CSR_DEBOUNCE_MS   = 2'd1,
      CSR_LONG_PRESS_MS = 2'd2,
      CSR_CLICK_GAP_MS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 pin_level;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic       held;
   } rsp_type;

   localparam logic [MsWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [MsWidth-1:0] LongPressReset = 16'd1000;
   localparam logic [MsWidth-1:0] ClickGapReset  = 16'd300;

endpackage

`default_nettype wire

FILE: hw/rtl/button_press_classifier.sv
// Button press classifier: debounce, short / long / double press detection.
// Depends on bpc_pkg.
//
// Usage: each transfer on the req_ channel is one poll of the button, carrying
// the raw pin level and a wrapping millisecond timestamp. Each poll produces
// exactly one transfer on the rsp_ channel with the event code (none, short,
// long, double) and the debounced held flag after that poll.
// The result of an accepted poll is registered: it goes into the result
// register, or into the skid entry when the receiver stalls. One poll per cycle
// is taken while req_stall is low; the whole update is a handful of 32-bit
// subtract-and-compare operations against the state registers, done between
// the request and the result register.
// A result register plus one skid entry sit on the output. When the receiver
// stalls, one more poll is accepted into the skid entry, after which req_stall
// rises until the receiver takes a result.
// Synchronous active-high reset restores the control registers to their
// defaults (active high, 50 ms debounce, 1000 ms long press, 300 ms gap),
// clears the press state and empties the output stages.
// The user must write control registers through the csr_ port only while idle; the block does not enforce it.
`default_nettype none

module button_press_classifier (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire bpc_pkg::req_type         req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output bpc_pkg::rsp_type              rsp_data,
   input  wire logic                     csr_wr_en,
   input  wire logic [bpc_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [bpc_pkg::MsWidth-1:0]     csr_wdata
);
   import bpc_pkg::*;

   // Control registers.
   logic               active_high_ff;
   logic [MsWidth-1:0] debounce_ff;
   logic [MsWidth-1:0] long_press_ff;
   logic [MsWidth-1:0] click_gap_ff;

   // Press state.
   logic                 raw_last_ff, raw_last_in;
   logic [TimeWidth-1:0] raw_change_ff, raw_change_in;
   logic                 steady_ff, steady_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic                 pressing_ff, pressing_in;
   logic                 long_seen_ff, long_seen_in;
   logic [1:0]           clicks_ff, clicks_in;
   logic [TimeWidth-1:0] release_ff, release_in;

   // Output stages.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   logic                 accept;
   logic                 lvl;
   logic [TimeWidth-1:0] now;
   logic [TimeWidth-1:0] raw_age, press_age, release_age;
   logic                 steady_chg, long_hit, gap_hit, pressing_mid, released_now;
   rsp_type              result;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= 1'b1;
         debounce_ff    <= DebounceReset;
         long_press_ff  <= LongPressReset;
         click_gap_ff   <= ClickGapReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_HIGH:   active_high_ff <= csr_wdata[0];
            CSR_DEBOUNCE_MS:   debounce_ff    <= csr_wdata;
            CSR_LONG_PRESS_MS: long_press_ff  <= csr_wdata;
            CSR_CLICK_GAP_MS:  click_gap_ff   <= csr_wdata;
         endcase
      end
   end

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign lvl = req_data.pin_level;
   assign now = req_data.now_ms;

   assign raw_age     = now - raw_change_ff;
   assign press_age   = now - press_start_ff;
   assign release_age = now - release_ff;

   // A raw edge in this poll restarts the stability timer at zero, so the
   // steady level can only move when the raw level matches the last sample.
   // Likewise a fresh press or a fresh release has zero age in this poll.
   assign steady_chg   = (lvl == raw_last_ff) && (lvl != steady_ff) &&
                         (raw_age > {{(TimeWidth-MsWidth){1'b0}}, debounce_ff});
   assign pressing_mid = steady_chg ? (lvl == active_high_ff) : pressing_ff;
   assign released_now = steady_chg && (lvl != active_high_ff) && !long_seen_ff;
   assign long_hit     = !steady_chg && pressing_ff && !long_seen_ff &&
                         (press_age > {{(TimeWidth-MsWidth){1'b0}}, long_press_ff});
   assign gap_hit      = !pressing_mid && !released_now && (clicks_ff != 2'd0) &&
                         (release_age > {{(TimeWidth-MsWidth){1'b0}}, click_gap_ff});

   always_comb begin
      raw_last_in    = lvl;
      raw_change_in  = (lvl != raw_last_ff) ? now : raw_change_ff;
      steady_in      = steady_ff;
      press_start_in = press_start_ff;
      pressing_in    = pressing_ff;
      long_seen_in   = long_seen_ff;
      clicks_in      = clicks_ff;
      release_in     = release_ff;
      result.event_res = EV_NONE;
      result.held      = pressing_mid;

      if (steady_chg) begin
         steady_in = lvl;
         if (lvl == active_high_ff) begin
            press_start_in = now;
            pressing_in    = 1'b1;
            long_seen_in   = 1'b0;
         end else begin
            pressing_in = 1'b0;
            if (!long_seen_ff) begin
               if (clicks_ff != 2'd3) begin
                  clicks_in = clicks_ff + 2'd1;
               end
               release_in = now;
            end
         end
      end

      priority if (long_hit) begin
         long_seen_in     = 1'b1;
         clicks_in        = 2'd0;
         result.event_res = EV_LONG;
      end else if (gap_hit) begin
         clicks_in = 2'd0;
         unique case (clicks_ff)
            2'd1:    result.event_res = EV_SHORT;
            2'd2:    result.event_res = EV_DOUBLE;
            default: result.event_res = EV_NONE;
         endcase
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff    <= 1'b0;
         raw_change_ff  <= '0;
         steady_ff      <= 1'b0;
         press_start_ff <= '0;
         pressing_ff    <= 1'b0;
         long_seen_ff   <= 1'b0;
         clicks_ff      <= 2'd0;
         release_ff     <= '0;
      end else if (accept) begin
         raw_last_ff    <= raw_last_in;
         raw_change_ff  <= raw_change_in;
         steady_ff      <= steady_in;
         press_start_ff <= press_start_in;
         pressing_ff    <= pressing_in;
         long_seen_ff   <= long_seen_in;
         clicks_ff      <= clicks_in;
         release_ff     <= release_in;
      end
   end

   // The skid entry catches a result when the output register is stalled;
   // it drains into the output register before any new poll is taken.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bpc_checker.sv
// Port-level checker for the button press classifier, bound to the top level.
// Depends on bpc_pkg.
`default_nettype none

module bpc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire bpc_pkg::rsp_type         rsp_data
);
   import bpc_pkg::*;

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Every accepted poll leaves a result waiting on the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted poll produced no result");

   // A long press is only reported while the button is held.
   a_long_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == EV_LONG |-> rsp_data.held)
      else $error("long press reported while released");

   // Click classification only happens with the button released.
   a_click_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_SHORT || rsp_data.event_res == EV_DOUBLE)
      |-> !rsp_data.held)
      else $error("click event reported while held");

   // Reset empties the output stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: tb/button_press_classifier_tb.sv
// Self-checking testbench for the button press classifier: directed and random polls
// against a cycle-free model of debounce and press classification. Depends on bpc_pkg.
`timescale 1ns / 100ps

module button_press_classifier_tb;
   import bpc_pkg::*;

   localparam int unsigned QuietLimit = 2000;
   localparam int unsigned SettleCycles = 6;

   // Opening polls under the reset settings, as {now_ms, pin_level}.
   localparam bit [32:0] DirectedPolls [25] = '{
      {32'd0, 1'b0}, {32'hFFFF_FFFF, 1'b1}, {32'd60, 1'b1}, {32'd100, 1'b0},
      {32'd160, 1'b0}, {32'd500, 1'b0}, {32'd510, 1'b1}, {32'd570, 1'b1},
      {32'd600, 1'b0}, {32'd660, 1'b0}, {32'd700, 1'b1}, {32'd760, 1'b1},
      {32'd800, 1'b0}, {32'd860, 1'b0}, {32'd1200, 1'b0}, {32'd1300, 1'b1},
      {32'd1360, 1'b1}, {32'd2400, 1'b1}, {32'd2500, 1'b0}, {32'd2560, 1'b0},
      {32'd2600, 1'b0}, {32'd100, 1'b1}, {32'd150, 1'b1}, {32'd151, 1'b1},
      {32'd152, 1'b0}
   };

   class press_checker;
      bit          active_high;
      bit [15:0]   debounce_ms;
      bit [15:0]   long_press_ms;
      bit [15:0]   click_gap_ms;
      bit          raw_last;
      bit          steady_level;
      bit          pressing;
      bit          long_seen;
      bit [1:0]    clicks;
      bit [31:0]   raw_change_ms;
      bit [31:0]   press_start_ms;
      bit [31:0]   release_ms;
      rsp_type     expected_events[$];
      int unsigned mismatches;

      function new();
         active_high   = 1'b1;
         debounce_ms   = DebounceReset;
         long_press_ms = LongPressReset;
         click_gap_ms  = ClickGapReset;
         raw_last      = 1'b0;
         steady_level  = 1'b0;
         mismatches    = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [15:0] value);
         case (idx)
            CSR_ACTIVE_HIGH:   active_high   = value[0];
            CSR_DEBOUNCE_MS:   debounce_ms   = value;
            CSR_LONG_PRESS_MS: long_press_ms = value;
            CSR_CLICK_GAP_MS:  click_gap_ms  = value;
            default: ;
         endcase
      endfunction

      function void note_poll(req_type poll);
         bit [31:0] since_change;
         bit [31:0] held_for;
         bit [31:0] quiet_for;
         event_type ev;
         ev = EV_NONE;
         if (poll.pin_level != raw_last) begin
            raw_change_ms = poll.now_ms;
            raw_last      = poll.pin_level;
         end
         since_change = poll.now_ms - raw_change_ms;
         if (since_change > debounce_ms && poll.pin_level != steady_level) begin
            steady_level = poll.pin_level;
            if (steady_level == active_high) begin
               press_start_ms = poll.now_ms;
               pressing       = 1'b1;
               long_seen      = 1'b0;
            end else begin
               pressing = 1'b0;
               // A release after a long press is not a click.
               if (!long_seen) begin
                  if (clicks != 2'd3)
                     clicks++;
                  release_ms = poll.now_ms;
               end
            end
         end
         held_for = poll.now_ms - press_start_ms;
         if (pressing && !long_seen && held_for > long_press_ms) begin
            long_seen = 1'b1;
            clicks    = 2'd0;
            ev        = EV_LONG;
         end
         quiet_for = poll.now_ms - release_ms;
         if (!pressing && clicks != 2'd0 && quiet_for > click_gap_ms) begin
            if (clicks == 2'd1)
               ev = EV_SHORT;
            else if (clicks == 2'd2)
               ev = EV_DOUBLE;
            clicks = 2'd0;
         end
         expected_events.push_back('{event_res: ev, held: pressing});
      endfunction

      function void complain(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] %s: expected event %0d held %0b, got event %0d held %0b",
                     $time, what, want.event_res, want.held, got.event_res, got.held);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            complain("result with no poll waiting", '0, got);
         end else begin
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res)
               complain("event mismatch", want, got);
            if (got.held !== want.held)
               complain("held mismatch", want, got);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [MsWidth-1:0]     csr_wdata = '0;

   press_checker sb;
   bit           calm = 1'b0;
   bit [31:0]    ms_now;
   int unsigned  polls_sent = 0;
   int unsigned  tick_ms;
   int unsigned  quiet_cycles = 0;

   button_press_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 35);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
         $display("FAIL button_press_classifier");
         $finish;
      end
   end

   task automatic send_poll(input req_type poll);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= poll;
      do @(posedge clock); while (req_stall);
      sb.note_poll(poll);
      polls_sent++;
   endtask

   task automatic poll_pin(input bit pin, input int unsigned step);
      ms_now += step;
      send_poll('{now_ms: ms_now, pin_level: pin});
   endtask

   // Holds the button pressed or released for at least dur milliseconds.
   task automatic hold_pin(input bit pressed, input int unsigned dur);
      int unsigned elapsed;
      int unsigned step;
      bit          pin;
      elapsed = 0;
      pin     = pressed ? sb.active_high : !sb.active_high;
      while (elapsed < dur) begin
         step = $urandom_range(1, 2 * tick_ms);
         elapsed += step;
         poll_pin(pin, step);
      end
   endtask

   // Contact chatter that settles on the given button state.
   task automatic bounce_into(input bit pressed);
      int unsigned step;
      bit          pin;
      pin = pressed ? sb.active_high : !sb.active_high;
      repeat ($urandom_range(1, 3)) begin
         step = $urandom_range(1, sb.debounce_ms / 4 + 1);
         poll_pin(!pin, step);
         poll_pin(pin, step);
      end
   endtask

   task automatic press_gesture();
      int unsigned clicks_wanted;
      int unsigned deb;
      int unsigned dur;
      bit          go_long;
      clicks_wanted = $urandom_range(1, 4);
      go_long       = ($urandom_range(3) == 0);
      deb           = sb.debounce_ms;
      for (int i = 1; i <= clicks_wanted; i++) begin
         if ($urandom_range(99) < 40)
            bounce_into(1'b1);
         if (go_long && i == clicks_wanted)
            dur = deb + sb.long_press_ms + $urandom_range(1, 4 * tick_ms);
         else
            dur = deb + $urandom_range(1, sb.long_press_ms / 2 + 1);
         hold_pin(1'b1, dur);
         if ($urandom_range(99) < 40)
            bounce_into(1'b0);
         if (i != clicks_wanted)
            hold_pin(1'b0, deb + $urandom_range(1, sb.click_gap_ms / 2 + 1));
      end
      hold_pin(1'b0, deb + sb.click_gap_ms + $urandom_range(1, 4 * tick_ms));
   endtask

   // Random levels with jumps of the clock, including backwards ones.
   task automatic noise_burst();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(2))
            0:       ms_now = $urandom;
            1:       ms_now -= $urandom_range(1, 5000);
            default: ms_now += $urandom_range(0, 200);
         endcase
         poll_pin(1'($urandom_range(1)), 0);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_events.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input bit [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_settings(input bit ah, input bit [15:0] deb, input bit [15:0] hold,
                                 input bit [15:0] gap);
      write_reg(CSR_ACTIVE_HIGH, {15'd0, ah});
      write_reg(CSR_DEBOUNCE_MS, deb);
      write_reg(CSR_LONG_PRESS_MS, hold);
      write_reg(CSR_CLICK_GAP_MS, gap);
   endtask

   task automatic run_phase(input int unsigned quota);
      int unsigned first;
      first   = polls_sent;
      tick_ms = (sb.debounce_ms + sb.long_press_ms + sb.click_gap_ms) / 24 + 1;
      while (polls_sent - first < quota) begin
         if ($urandom_range(99) < 80)
            press_gesture();
         else
            noise_burst();
         if ($urandom_range(99) < 4)
            wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedPolls[i])
         send_poll(req_type'(DirectedPolls[i]));
      ms_now = 32'd152;
      run_phase(120);

      // The polarity flips without a reset, so the stored levels stay as they were.
      apply_settings(1'b0, 16'd50, 16'd1000, 16'd300);
      run_phase(150);

      calm = 1'b1;
      apply_settings(1'b1, 16'd0, 16'd0, 16'd0);
      run_phase(150);
      calm = 1'b0;

      apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(150);

      apply_settings(1'b1, 16'd20, 16'd400, 16'd150);
      run_phase(150);

      apply_settings(1'($urandom_range(1)), 16'($urandom_range(255)),
                     16'($urandom_range(4095)), 16'($urandom_range(1023)));
      run_phase(150);

      apply_settings(1'($urandom_range(1)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)));
      run_phase(150);

      apply_settings(1'b1, 16'd1, 16'hFFFF, 16'd0);
      run_phase(150);

      apply_settings(1'b1, 16'd50, 16'd1000, 16'd300);
      run_phase(130);

      repeat (SettleCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_events.size() == 0)
         $display("PASS button_press_classifier");
      else
         $display("FAIL button_press_classifier");
      $finish;
   end

endmodule
